@@ design/interp_table_u16_assert.svh @@
// ----------------------------------------------------------------------------
// interp_table_u16 assertion macros
// Shared property macros for the checker of the lookup table block.
// ----------------------------------------------------------------------------
`ifndef INTERP_TABLE_U16_ASSERT_SVH
`define INTERP_TABLE_U16_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/itu_pkg.sv @@
// ----------------------------------------------------------------------------
// itu_pkg
// Types and constants shared by the lookup table interpolator.
// ----------------------------------------------------------------------------
package itu_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int DATA_W     = 16;
    localparam int LEN_W      = 5;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int CNT_W      = $clog2(DATA_W + 1);
    localparam int ADDR_W     = 3;

    localparam logic [LEN_W-1:0]  LEN_RESET         = LEN_W'(16);
    localparam logic [ADDR_W-1:0] ADDR_ACTIVE_LENGTH = ADDR_W'(0);

    localparam logic [1:0] KIND_SET_Y   = 2'd0;
    localparam logic [1:0] KIND_FILL_X  = 2'd1;
    localparam logic [1:0] KIND_INTERP  = 2'd2;
    localparam logic [1:0] KIND_NEAREST = 2'd3;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_YWRITE,
        CMD_FAULT,
        CMD_DIV,
        CMD_CHK_HI,
        CMD_CHK_LO,
        CMD_SCAN,
        CMD_RD_Y0,
        CMD_MUL,
        CMD_LERP_END,
        CMD_FILL_INIT,
        CMD_FILL_WR,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       inverted;
        logic       at_hi;
        logic       at_lo;
        logic       hit;
        logic       at_last;
        logic       div_done;
    } t_status;

endpackage

@@ design/itu_if.sv @@
// ----------------------------------------------------------------------------
// itu_in_if / itu_out_if
// Valid/ready channels carrying query items and result items.
// ----------------------------------------------------------------------------
interface itu_in_if
    import itu_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] x_value;
    logic [DATA_W-1:0] x_max;
    logic [DATA_W-1:0] y_value;
    modport source (output valid, kind, index, x_value, x_max, y_value, input ready);
    modport sink   (input valid, kind, index, x_value, x_max, y_value, output ready);
endinterface

interface itu_out_if
    import itu_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] y_result;
    logic [IDX_W-1:0]  position;
    logic              saturated;
    logic              fault;
    modport source (output valid, y_result, position, saturated, fault, input ready);
    modport sink   (input valid, y_result, position, saturated, fault, output ready);
endinterface

@@ design/itu_div.sv @@
// ----------------------------------------------------------------------------
// itu_div
// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor so the quotient fits in DATA_W bits.
// ----------------------------------------------------------------------------
module itu_div
    import itu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic [DATA_W-1:0] o_quotient,
    output logic              o_rem_nz,
    output logic              o_done
);

    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W:0]   trial;
    logic              take;

    assign trial = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign take  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DATA_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend[PROD_W-1:DATA_W]};
            r_quo <= i_dividend[DATA_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[DATA_W-2:0], take};
        end
    end

    assign o_quotient = r_quo;
    assign o_rem_nz   = r_rem != '0;
    assign o_done     = r_done;

endmodule

@@ design/itu_datapath.sv @@
// ----------------------------------------------------------------------------
// itu_datapath
// Breakpoint tables, working registers, multiplier and result registers.
// ----------------------------------------------------------------------------
module itu_datapath
    import itu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [LEN_W-1:0]  i_active_length,
    input  logic [1:0]        i_kind,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [DATA_W-1:0] i_x_value,
    input  logic [DATA_W-1:0] i_x_max,
    input  logic [DATA_W-1:0] i_y_value,
    output t_status           o_status,
    output logic [DATA_W-1:0] o_y_result,
    output logic [IDX_W-1:0]  o_position,
    output logic              o_saturated,
    output logic              o_fault
);

    logic [DATA_W-1:0] r_x_mem [MAX_POINTS];
    logic [DATA_W-1:0] r_y_mem [MAX_POINTS];

    logic [1:0]        r_kind;
    logic [IDX_W-1:0]  r_index;
    logic [DATA_W-1:0] r_xv, r_xmax, r_yv;
    logic [IDX_W-1:0]  r_i;
    logic [DATA_W-1:0] r_prev, r_x1, r_y0, r_y1, r_span, r_step, r_acc;
    logic [PROD_W-1:0] r_prod;
    logic              r_dyneg;
    logic [DATA_W-1:0] r_res_y;
    logic [IDX_W-1:0]  r_res_pos;
    logic              r_res_sat, r_res_flt;

    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  rd_idx;
    logic [DATA_W-1:0] x_rd, y_rd;
    logic [DATA_W:0]   mid_sum;
    logic [DATA_W-1:0] mid;
    logic [IDX_W-1:0]  near_pos;
    logic [DATA_W-1:0] abs_dy;
    logic [DATA_W-1:0] quo;
    logic              rem_nz, div_done;
    logic [PROD_W-1:0] div_num;
    logic [DATA_W-1:0] div_den;

    // Length clamped to the legal range of two to MAX_POINTS entries.
    always_comb begin
        priority if (i_active_length < LEN_W'(2)) begin
            last_idx = IDX_W'(1);
        end else if (i_active_length > LEN_W'(MAX_POINTS)) begin
            last_idx = IDX_W'(MAX_POINTS - 1);
        end else begin
            last_idx = IDX_W'(i_active_length - 1'b1);
        end
    end

    always_comb begin
        unique case (i_cmd)
            CMD_CHK_HI: rd_idx = last_idx;
            CMD_CHK_LO: rd_idx = '0;
            CMD_RD_Y0:  rd_idx = r_i - 1'b1;
            default:    rd_idx = r_i;
        endcase
    end

    assign x_rd = r_x_mem[rd_idx];
    assign y_rd = r_y_mem[rd_idx];

    assign mid_sum = {1'b0, r_prev} + {1'b0, x_rd};
    assign mid     = mid_sum[DATA_W:1];
    always_comb begin
        if (r_prev < x_rd) begin
            near_pos = (r_xv < mid) ? (r_i - 1'b1) : r_i;
        end else begin
            near_pos = (r_xv > mid) ? (r_i - 1'b1) : r_i;
        end
    end

    assign abs_dy = (r_y1 < r_y0) ? (r_y0 - r_y1) : (r_y1 - r_y0);

    assign div_num = (r_kind == KIND_FILL_X) ? {{DATA_W{1'b0}}, r_xmax - r_xv} : r_prod;
    assign div_den = (r_kind == KIND_FILL_X) ? DATA_W'(last_idx) : r_span;

    itu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd == CMD_DIV),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_quotient (quo),
        .o_rem_nz   (rem_nz),
        .o_done     (div_done)
    );

    always_comb begin
        o_status.kind     = r_kind;
        o_status.inverted = r_xmax < r_xv;
        o_status.at_hi    = r_xv >= x_rd;
        o_status.at_lo    = r_xv <= x_rd;
        o_status.hit      = (r_prev <= r_xv) && (x_rd >= r_xv);
        o_status.at_last  = r_i == last_idx;
        o_status.div_done = div_done;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_kind    <= i_kind;
                r_index   <= i_index;
                r_xv      <= i_x_value;
                r_xmax    <= i_x_max;
                r_yv      <= i_y_value;
                r_res_y   <= '0;
                r_res_pos <= '0;
                r_res_sat <= 1'b0;
                r_res_flt <= 1'b0;
            end
            CMD_YWRITE: r_y_mem[r_index] <= r_yv;
            CMD_FAULT:  r_res_flt <= 1'b1;
            CMD_CHK_HI: begin
                if (o_status.at_hi) begin
                    r_res_sat <= 1'b1;
                    r_res_pos <= last_idx;
                    if (r_kind == KIND_INTERP) r_res_y <= y_rd;
                end
            end
            CMD_CHK_LO: begin
                if (o_status.at_lo) begin
                    r_res_sat <= 1'b1;
                    if (r_kind == KIND_INTERP) r_res_y <= y_rd;
                end
                r_prev <= x_rd;
                r_i    <= IDX_W'(1);
            end
            CMD_SCAN: begin
                if (o_status.hit) begin
                    r_x1      <= x_rd;
                    r_y1      <= y_rd;
                    r_res_pos <= (r_kind == KIND_NEAREST) ? near_pos : (r_i - 1'b1);
                end else if (o_status.at_last) begin
                    r_res_flt <= 1'b1;
                    r_res_pos <= last_idx;
                    if (r_kind == KIND_INTERP) r_res_y <= y_rd;
                end else begin
                    r_prev <= x_rd;
                    r_i    <= r_i + 1'b1;
                end
            end
            CMD_RD_Y0: r_y0 <= y_rd;
            CMD_MUL: begin
                r_prod  <= (r_xv - r_prev) * abs_dy;
                r_span  <= r_x1 - r_prev;
                r_dyneg <= r_y1 < r_y0;
            end
            CMD_LERP_END: begin
                // Exact floor: a falling segment rounds the magnitude up.
                priority if (r_xv <= r_prev) begin
                    r_res_y <= r_y0;
                end else if (r_xv >= r_x1) begin
                    r_res_y <= r_y1;
                end else if (r_dyneg) begin
                    r_res_y <= r_y0 - quo - DATA_W'(rem_nz);
                end else begin
                    r_res_y <= r_y0 + quo;
                end
            end
            CMD_FILL_INIT: begin
                r_step <= quo;
                r_acc  <= r_xv;
                r_i    <= '0;
            end
            CMD_FILL_WR: begin
                r_x_mem[r_i] <= r_acc;
                r_acc        <= r_acc + r_step;
                r_i          <= r_i + 1'b1;
            end
            CMD_FINISH: begin
                o_y_result  <= r_res_y;
                o_position  <= r_res_pos;
                o_saturated <= r_res_sat;
                o_fault     <= r_res_flt;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ design/itu_ctrl.sv @@
// ----------------------------------------------------------------------------
// itu_ctrl
// Sequencer that steps the datapath through one item at a time.
// ----------------------------------------------------------------------------
module itu_ctrl
    import itu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_DISP = 11'b00000000010,
        ST_LO   = 11'b00000000100,
        ST_SCAN = 11'b00000001000,
        ST_Y0   = 11'b00000010000,
        ST_MUL  = 11'b00000100000,
        ST_DIV  = 11'b00001000000,
        ST_DIVW = 11'b00010000000,
        ST_POST = 11'b00100000000,
        ST_FILL = 11'b01000000000,
        ST_DONE = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = r_state == ST_IDLE;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (i_status.kind)
                    KIND_SET_Y: begin
                        o_cmd   = CMD_YWRITE;
                        n_state = ST_DONE;
                    end
                    KIND_FILL_X: begin
                        o_cmd   = i_status.inverted ? CMD_FAULT : CMD_DIV;
                        n_state = i_status.inverted ? ST_DONE : ST_DIVW;
                    end
                    default: begin
                        o_cmd   = CMD_CHK_HI;
                        n_state = i_status.at_hi ? ST_DONE : ST_LO;
                    end
                endcase
            end
            ST_LO: begin
                o_cmd   = CMD_CHK_LO;
                n_state = i_status.at_lo ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd = CMD_SCAN;
                if (i_status.hit) begin
                    n_state = (i_status.kind == KIND_INTERP) ? ST_Y0 : ST_DONE;
                end else if (i_status.at_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_Y0: begin
                o_cmd   = CMD_RD_Y0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd   = CMD_MUL;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd   = CMD_DIV;
                n_state = ST_DIVW;
            end
            ST_DIVW: begin
                if (i_status.div_done) n_state = ST_POST;
            end
            ST_POST: begin
                if (i_status.kind == KIND_FILL_X) begin
                    o_cmd   = CMD_FILL_INIT;
                    n_state = ST_FILL;
                end else begin
                    o_cmd   = CMD_LERP_END;
                    n_state = ST_DONE;
                end
            end
            ST_FILL: begin
                o_cmd = CMD_FILL_WR;
                if (i_status.at_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd       = CMD_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/interp_table_u16.sv @@
// ----------------------------------------------------------------------------
// interp_table_u16
// Piecewise-linear lookup table with 16-bit x and y breakpoints.
// ----------------------------------------------------------------------------
// Usage: items arrive on the i_in channel and each produces exactly one
// result transfer on the o_out channel. Kind 0 writes a y entry, kind 1
// spaces the x entries evenly, kind 2 interpolates and kind 3 reports the
// nearest breakpoint. The number of breakpoints in use is set through the
// APB port (register 0, active_length, reset value 16); the user must write
// it only while the block is idle; the block itself does not enforce this.
//
// The block works on one item at a time. A query checks the upper, then the
// lower table end; if x lies between them the segments are scanned in turn,
// and an interpolation then reads y0, multiplies and runs the restoring
// division. An even fill runs the division, then writes the x entries in
// turn. The segment scan and the one-bit-per-cycle divider set how long an
// item takes.
//
// After reset the sequencer is idle and no result is pending. The tables
// hold nothing defined until written. A finished result sits in an output
// register; when the receiver stalls, the next item is still accepted and
// worked on, and its result waits until the pending transfer completes.
// ----------------------------------------------------------------------------
module interp_table_u16
    import itu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    itu_in_if.sink            i_in,
    itu_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [LEN_W-1:0] r_active_length;
    t_cmd             cmd;
    t_status          status;

    // The only register is active_length; writes elsewhere are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= LEN_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_ACTIVE_LENGTH) begin
            r_active_length <= pwdata[LEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ACTIVE_LENGTH) ? {{(32 - LEN_W){1'b0}}, r_active_length}
                                                  : 32'd0;

    // The sequencer issues one command per cycle and watches the status.
    itu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds both tables and the result register.
    itu_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_active_length (r_active_length),
        .i_kind          (i_in.kind),
        .i_index         (i_in.index),
        .i_x_value       (i_in.x_value),
        .i_x_max         (i_in.x_max),
        .i_y_value       (i_in.y_value),
        .o_status        (status),
        .o_y_result      (o_out.y_result),
        .o_position      (o_out.position),
        .o_saturated     (o_out.saturated),
        .o_fault         (o_out.fault)
    );

endmodule

@@ design/itu_checker.sv @@
// ----------------------------------------------------------------------------
// itu_checker
// Port-level checks of the lookup table block, bound to the top level.
// ----------------------------------------------------------------------------
`include "interp_table_u16_assert.svh"

module itu_checker
    import itu_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_y_result,
    input logic [IDX_W-1:0]  i_position,
    input logic              i_saturated,
    input logic              i_fault
);

    // One item at a time: the block is busy right after taking an item.
    `ITU_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A stalled result holds its payload.
    `ITU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_y_result) && $stable(i_position) && $stable(i_saturated) && $stable(i_fault))

    // An end clamp and a missing segment never come together.
    `ITU_ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, i_out_valid, !(i_saturated && i_fault))

endmodule

bind interp_table_u16 itu_checker u_itu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_y_result  (o_out.y_result),
    .i_position  (o_out.position),
    .i_saturated (o_out.saturated),
    .i_fault     (o_out.fault)
);
